// ===== rtl/coulomb_friction_contact_force_unit_defines.svh =====
// Assertion macros shared by the RTL of the contact force unit.
// Each macro checks a property on the rising edge of clk, held off while arst_n is low.
`ifndef COULOMB_FRICTION_CONTACT_FORCE_UNIT_DEFINES_SVH
`define COULOMB_FRICTION_CONTACT_FORCE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CFCF_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("contact force unit: same-cycle check failed");
`define CFCF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("contact force unit: next-cycle check failed");
`else
`define CFCF_ASSERT_SAME(lbl, ante, cons)
`define CFCF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/cfcf_pkg.sv =====
package cfcf_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int ROOT_STEPS = 32;

	localparam logic REG_NO_BREAK = 1'b0;
	localparam logic REG_NO_SLIP  = 1'b1;

	// Per-contact data that rides alongside the root and quotient chains.
	typedef struct packed {
		logic               broken;
		logic               slip;
		logic signed [31:0] fn;
		logic signed [31:0] f1;
		logic signed [31:0] f2;
		logic signed [32:0] rel_t1;
		logic signed [32:0] rel_t2;
		logic signed [31:0] pl1;
		logic signed [31:0] pl2;
		logic        [31:0] cap;
	} side_t;

endpackage

// ===== rtl/cfcf_if.sv =====
interface cfcf_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] disp_n;
	logic signed [31:0] disp_t1;
	logic signed [31:0] disp_t2;
	logic signed [31:0] plastic_n;
	logic signed [31:0] plastic_t1;
	logic signed [31:0] plastic_t2;
	logic        [30:0] stiff_n;
	logic        [30:0] stiff_t;
	logic        [30:0] tan_friction;

	modport source (output valid, disp_n, disp_t1, disp_t2, plastic_n, plastic_t1,
		plastic_t2, stiff_n, stiff_t, tan_friction, input ready);
	modport sink (input valid, disp_n, disp_t1, disp_t2, plastic_n, plastic_t1,
		plastic_t2, stiff_n, stiff_t, tan_friction, output ready);
endinterface

interface cfcf_out_if;
	logic               valid;
	logic               ready;
	logic               broken;
	logic signed [31:0] force_n;
	logic signed [31:0] force_t1;
	logic signed [31:0] force_t2;
	logic signed [31:0] new_plastic_t1;
	logic signed [31:0] new_plastic_t2;
	logic               slipping;

	modport source (output valid, broken, force_n, force_t1, force_t2, new_plastic_t1,
		new_plastic_t2, slipping, input ready);
	modport sink (input valid, broken, force_n, force_t1, force_t2, new_plastic_t1,
		new_plastic_t2, slipping, output ready);
endinterface

// ===== rtl/cfcf_sqrt_cell.sv =====
// One digit of the integer square root: settles one result bit per cell.
module cfcf_sqrt_cell
	import cfcf_pkg::*;
#(
	parameter int STEP = 0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        next_take,
	output logic        take,
	input  logic        v_in,
	input  logic [63:0] rem_in,
	input  logic [63:0] res_in,
	input  side_t       side_in,
	output logic        v_out,
	output logic [63:0] rem_out,
	output logic [63:0] res_out,
	output side_t       side_out
);

	logic        v_q;
	logic [63:0] rem_q;
	logic [63:0] res_q;
	side_t       side_q;
	logic [63:0] bitv;
	logic [63:0] trial;
	logic        ge;

	assign bitv  = 64'd1 << (2 * STEP);
	assign trial = res_in + bitv;
	assign ge    = rem_in >= trial;
	assign take  = !v_q || next_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (take) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rem_q  <= ge ? rem_in - trial : rem_in;
			res_q  <= ge ? (res_in >> 1) + bitv : res_in >> 1;
			side_q <= side_in;
		end
	end

	assign v_out    = v_q;
	assign rem_out  = rem_q;
	assign res_out  = res_q;
	assign side_out = side_q;

endmodule

// ===== rtl/cfcf_div_cell.sv =====
// One restoring-division step: yields one quotient bit per cell.
module cfcf_div_cell
	import cfcf_pkg::*;
#(
	parameter int QW    = 17,
	parameter bit FIRST = 1'b0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          next_take,
	output logic          take,
	input  logic          v_in,
	input  logic [32:0]   rem_in,
	input  logic [31:0]   den_in,
	input  logic [QW-1:0] q_in,
	input  side_t         side_in,
	output logic          v_out,
	output logic [32:0]   rem_out,
	output logic [31:0]   den_out,
	output logic [QW-1:0] q_out,
	output side_t         side_out
);

	logic          v_q;
	logic [32:0]   rem_q;
	logic [31:0]   den_q;
	logic [QW-1:0] q_q;
	side_t         side_q;
	logic [32:0]   t;
	logic          ge;

	assign t    = FIRST ? rem_in : {rem_in[31:0], 1'b0};
	assign ge   = t >= {1'b0, den_in};
	assign take = !v_q || next_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (take) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rem_q  <= ge ? t - {1'b0, den_in} : t;
			den_q  <= den_in;
			q_q    <= {q_in[QW-2:0], ge};
			side_q <= side_in;
		end
	end

	assign v_out    = v_q;
	assign rem_out  = rem_q;
	assign den_out  = den_q;
	assign q_out    = q_q;
	assign side_out = side_q;

endmodule

// ===== rtl/coulomb_friction_contact_force_unit.sv =====
// Throughput: one word per cycle unless res.ready stalls the output. Values are Q16.16 by default;
// the pipeline is set by the 32-cell square root chain and the FRAC_BITS+1-cell divider chain,
// each cell settling one bit per cycle.
// Any stage that is empty or whose successor moves takes new data, so stalls compress bubbles.
// Reset (arst_n low, asynchronous) clears every stage valid and both config bits to 0.
`include "coulomb_friction_contact_force_unit_defines.svh"
module coulomb_friction_contact_force_unit
	import cfcf_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic cfg_data,
	cfcf_in_if.sink    inp,
	cfcf_out_if.source res
);

	localparam int QW = FRAC_BITS + 1;

	// Fixed-point product of a signed value and an unsigned stiffness, truncated
	// toward zero and saturated to 32-bit signed.
	function automatic logic signed [31:0] mul_sat(input logic signed [32:0] a,
		input logic [30:0] b);
		logic [32:0] m;
		logic [63:0] p;
		logic [63:0] sh;
		logic [31:0] r;
		m  = a[32] ? 33'(-a) : 33'(a);
		p  = 64'(m) * 64'(b);
		sh = p >> FRAC_BITS;
		if (a[32]) begin
			r = (sh > 64'h8000_0000) ? 32'h8000_0000 : 32'(-sh);
		end else begin
			r = (sh > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : sh[31:0];
		end
		return r;
	endfunction

	// Configuration registers; the user must write them only while the unit is idle, as the block does not enforce it.
	logic no_break_q;
	logic no_slip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			no_break_q <= 1'b0;
			no_slip_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NO_BREAK: no_break_q <= cfg_data;
				REG_NO_SLIP:  no_slip_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage valids and the take chain. A stage takes new data when it is empty
	// or when its content moves on in the same cycle.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_o_q;
	logic take_s1, take_s2, take_s3, take_s4, take_s5, take_s6, take_o;
	logic sq_take [0:ROOT_STEPS];
	logic dv_take [0:QW];

	assign take_o  = !v_o_q || res.ready;
	assign take_s6 = !v_s6 || take_o;
	assign take_s5 = !v_s5 || sq_take[0];
	assign take_s4 = !v_s4 || take_s5;
	assign take_s3 = !v_s3 || take_s4;
	assign take_s2 = !v_s2 || take_s3;
	assign take_s1 = !v_s1 || take_s2;
	assign inp.ready = take_s1;

	// Stage 1: relative displacements, kept exact at 33 bits.
	logic signed [32:0] rel_n_s1, rel_t1_s1, rel_t2_s1;
	logic signed [31:0] pl1_s1, pl2_s1;
	logic        [30:0] kn_s1, ks_s1, tf_s1;

	// Stage 2: saturated normal and shear forces.
	logic signed [31:0] fn_s2, f1_s2, f2_s2;
	logic signed [32:0] rel_t1_s2, rel_t2_s2;
	logic signed [31:0] pl1_s2, pl2_s2;
	logic        [30:0] tf_s2;

	// Stage 3: shear cap, squared shear magnitudes and the break decision.
	logic signed [31:0] fn_s3, f1_s3, f2_s3;
	logic signed [32:0] rel_t1_s3, rel_t2_s3;
	logic signed [31:0] pl1_s3, pl2_s3;
	logic        [31:0] cap_s3;
	logic        [63:0] sq1_s3, sq2_s3;
	logic               broken_s3;

	// Stage 4: squared shear sum and squared cap.
	logic signed [31:0] fn_s4, f1_s4, f2_s4;
	logic signed [32:0] rel_t1_s4, rel_t2_s4;
	logic signed [31:0] pl1_s4, pl2_s4;
	logic        [31:0] cap_s4;
	logic        [63:0] ssum_s4, capsq_s4;
	logic               broken_s4;

	// Stage 5: slip decision, packed for the root chain.
	side_t       side_s5;
	logic [63:0] ssum_s5;

	logic [31:0] a1, a2, fn_mag;
	logic [63:0] cap_p, cap_sh;

	assign a1     = f1_s2[31] ? 32'(-f1_s2) : 32'(f1_s2);
	assign a2     = f2_s2[31] ? 32'(-f2_s2) : 32'(f2_s2);
	assign fn_mag = 32'(-fn_s2);
	assign cap_p  = 64'(fn_mag) * 64'(tf_s2);
	assign cap_sh = cap_p >> FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (take_s1) begin
				v_s1 <= inp.valid;
			end
			if (take_s2) begin
				v_s2 <= v_s1;
			end
			if (take_s3) begin
				v_s3 <= v_s2;
			end
			if (take_s4) begin
				v_s4 <= v_s3;
			end
			if (take_s5) begin
				v_s5 <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			rel_n_s1  <= 33'(inp.disp_n) - 33'(inp.plastic_n);
			rel_t1_s1 <= 33'(inp.disp_t1) - 33'(inp.plastic_t1);
			rel_t2_s1 <= 33'(inp.disp_t2) - 33'(inp.plastic_t2);
			pl1_s1    <= inp.plastic_t1;
			pl2_s1    <= inp.plastic_t2;
			kn_s1     <= inp.stiff_n;
			ks_s1     <= inp.stiff_t;
			tf_s1     <= inp.tan_friction;
		end
		if (take_s2) begin
			fn_s2     <= mul_sat(rel_n_s1, kn_s1);
			f1_s2     <= mul_sat(rel_t1_s1, ks_s1);
			f2_s2     <= mul_sat(rel_t2_s1, ks_s1);
			rel_t1_s2 <= rel_t1_s1;
			rel_t2_s2 <= rel_t2_s1;
			pl1_s2    <= pl1_s1;
			pl2_s2    <= pl2_s1;
			tf_s2     <= tf_s1;
		end
		if (take_s3) begin
			fn_s3     <= fn_s2;
			f1_s3     <= f1_s2;
			f2_s3     <= f2_s2;
			rel_t1_s3 <= rel_t1_s2;
			rel_t2_s3 <= rel_t2_s2;
			pl1_s3    <= pl1_s2;
			pl2_s3    <= pl2_s2;
			// Only a compressive normal force supports any shear.
			if (fn_s2[31]) begin
				cap_s3 <= (cap_sh > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : cap_sh[31:0];
			end else begin
				cap_s3 <= 32'd0;
			end
			sq1_s3    <= 64'(a1) * 64'(a1);
			sq2_s3    <= 64'(a2) * 64'(a2);
			broken_s3 <= !fn_s2[31] && (fn_s2 != 32'sd0) && !no_break_q;
		end
		if (take_s4) begin
			fn_s4     <= fn_s3;
			f1_s4     <= f1_s3;
			f2_s4     <= f2_s3;
			rel_t1_s4 <= rel_t1_s3;
			rel_t2_s4 <= rel_t2_s3;
			pl1_s4    <= pl1_s3;
			pl2_s4    <= pl2_s3;
			cap_s4    <= cap_s3;
			ssum_s4   <= sq1_s3 + sq2_s3;
			capsq_s4  <= 64'(cap_s3) * 64'(cap_s3);
			broken_s4 <= broken_s3;
		end
		if (take_s5) begin
			side_s5.broken <= broken_s4;
			side_s5.slip   <= !broken_s4 && !no_slip_q && (ssum_s4 > capsq_s4);
			side_s5.fn     <= fn_s4;
			side_s5.f1     <= f1_s4;
			side_s5.f2     <= f2_s4;
			side_s5.rel_t1 <= rel_t1_s4;
			side_s5.rel_t2 <= rel_t2_s4;
			side_s5.pl1    <= pl1_s4;
			side_s5.pl2    <= pl2_s4;
			side_s5.cap    <= cap_s4;
			ssum_s5        <= ssum_s4;
		end
	end

	// Square root chain: cell k settles root bit ROOT_STEPS-1-k of the shear magnitude.
	logic        sq_v    [0:ROOT_STEPS];
	logic [63:0] sq_rem  [0:ROOT_STEPS];
	logic [63:0] sq_res  [0:ROOT_STEPS];
	side_t       sq_side [0:ROOT_STEPS];

	assign sq_v[0]    = v_s5;
	assign sq_rem[0]  = ssum_s5;
	assign sq_res[0]  = 64'd0;
	assign sq_side[0] = side_s5;
	assign sq_take[ROOT_STEPS] = dv_take[0];

	for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
		cfcf_sqrt_cell #(
			.STEP(ROOT_STEPS - 1 - k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.next_take(sq_take[k+1]),
			.take     (sq_take[k]),
			.v_in     (sq_v[k]),
			.rem_in   (sq_rem[k]),
			.res_in   (sq_res[k]),
			.side_in  (sq_side[k]),
			.v_out    (sq_v[k+1]),
			.rem_out  (sq_rem[k+1]),
			.res_out  (sq_res[k+1]),
			.side_out (sq_side[k+1])
		);
	end

	// Divider chain: ratio = cap * 2^FRAC_BITS / magnitude. On slip the magnitude is
	// at least the cap, so the quotient never exceeds one and fits FRAC_BITS+1 bits.
	logic          dv_v    [0:QW];
	logic [32:0]   dv_rem  [0:QW];
	logic [31:0]   dv_den  [0:QW];
	logic [QW-1:0] dv_q    [0:QW];
	side_t         dv_side [0:QW];

	assign dv_v[0]    = sq_v[ROOT_STEPS];
	assign dv_rem[0]  = {1'b0, sq_side[ROOT_STEPS].cap};
	assign dv_den[0]  = sq_res[ROOT_STEPS][31:0];
	assign dv_q[0]    = '0;
	assign dv_side[0] = sq_side[ROOT_STEPS];
	assign dv_take[QW] = take_s6;

	for (genvar j = 0; j < QW; j++) begin : g_div
		cfcf_div_cell #(
			.QW   (QW),
			.FIRST(j == 0)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.next_take(dv_take[j+1]),
			.take     (dv_take[j]),
			.v_in     (dv_v[j]),
			.rem_in   (dv_rem[j]),
			.den_in   (dv_den[j]),
			.q_in     (dv_q[j]),
			.side_in  (dv_side[j]),
			.v_out    (dv_v[j+1]),
			.rem_out  (dv_rem[j+1]),
			.den_out  (dv_den[j+1]),
			.q_out    (dv_q[j+1]),
			.side_out (dv_side[j+1])
		);
	end

	// Stage 6: scaled shear forces and the plastic increments.
	side_t              side_d;
	logic [QW-1:0]      ratio;
	logic [QW-1:0]      one_m_ratio;
	logic [31:0]        m1, m2;
	logic [32:0]        r1, r2;
	logic [63:0]        pf1, pf2, pp1, pp2;
	logic [63:0]        pf1_sh, pf2_sh, pp1_sh, pp2_sh;

	side_t              side_s6;
	logic signed [31:0] sf1_s6, sf2_s6;
	logic signed [34:0] dp1_s6, dp2_s6;

	assign side_d      = dv_side[QW];
	assign ratio       = dv_q[QW];
	assign one_m_ratio = (QW'(1) << FRAC_BITS) - ratio;
	assign m1 = side_d.f1[31] ? 32'(-side_d.f1) : 32'(side_d.f1);
	assign m2 = side_d.f2[31] ? 32'(-side_d.f2) : 32'(side_d.f2);
	assign r1 = side_d.rel_t1[32] ? 33'(-side_d.rel_t1) : 33'(side_d.rel_t1);
	assign r2 = side_d.rel_t2[32] ? 33'(-side_d.rel_t2) : 33'(side_d.rel_t2);
	assign pf1 = 64'(m1) * 64'(ratio);
	assign pf2 = 64'(m2) * 64'(ratio);
	assign pp1 = 64'(r1) * 64'(one_m_ratio);
	assign pp2 = 64'(r2) * 64'(one_m_ratio);
	assign pf1_sh = pf1 >> FRAC_BITS;
	assign pf2_sh = pf2 >> FRAC_BITS;
	assign pp1_sh = pp1 >> FRAC_BITS;
	assign pp2_sh = pp2 >> FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6  <= 1'b0;
			v_o_q <= 1'b0;
		end else begin
			if (take_s6) begin
				v_s6 <= dv_v[QW];
			end
			if (take_o) begin
				v_o_q <= v_s6;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s6) begin
			side_s6 <= side_d;
			sf1_s6  <= side_d.f1[31] ? 32'(-pf1_sh) : pf1_sh[31:0];
			sf2_s6  <= side_d.f2[31] ? 32'(-pf2_sh) : pf2_sh[31:0];
			dp1_s6  <= side_d.rel_t1[32] ? 35'(-pp1_sh) : pp1_sh[34:0];
			dp2_s6  <= side_d.rel_t2[32] ? 35'(-pp2_sh) : pp2_sh[34:0];
		end
	end

	// Output register: final selection and saturation of the new plastic offsets.
	logic signed [34:0] np1_sum, np2_sum;
	logic signed [31:0] np1_sat, np2_sat;

	logic               broken_q;
	logic signed [31:0] force_n_q, force_t1_q, force_t2_q;
	logic signed [31:0] new_plastic_t1_q, new_plastic_t2_q;
	logic               slipping_q;

	assign np1_sum = 35'(side_s6.pl1) + dp1_s6;
	assign np2_sum = 35'(side_s6.pl2) + dp2_s6;
	assign np1_sat = (np1_sum > 35'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
		(np1_sum < -35'sh0_8000_0000) ? 32'sh8000_0000 : np1_sum[31:0];
	assign np2_sat = (np2_sum > 35'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
		(np2_sum < -35'sh0_8000_0000) ? 32'sh8000_0000 : np2_sum[31:0];

	always_ff @(posedge clk) begin
		if (take_o) begin
			broken_q         <= side_s6.broken;
			slipping_q       <= side_s6.slip;
			new_plastic_t1_q <= side_s6.slip ? np1_sat : side_s6.pl1;
			new_plastic_t2_q <= side_s6.slip ? np2_sat : side_s6.pl2;
			if (side_s6.broken) begin
				// A broken contact reports no force at all.
				force_n_q  <= 32'sd0;
				force_t1_q <= 32'sd0;
				force_t2_q <= 32'sd0;
			end else begin
				force_n_q  <= side_s6.fn;
				force_t1_q <= side_s6.slip ? sf1_s6 : side_s6.f1;
				force_t2_q <= side_s6.slip ? sf2_s6 : side_s6.f2;
			end
		end
	end

	assign res.valid          = v_o_q;
	assign res.broken         = broken_q;
	assign res.force_n        = force_n_q;
	assign res.force_t1       = force_t1_q;
	assign res.force_t2       = force_t2_q;
	assign res.new_plastic_t1 = new_plastic_t1_q;
	assign res.new_plastic_t2 = new_plastic_t2_q;
	assign res.slipping       = slipping_q;

	// A broken contact never slips and carries zero normal and t1 shear forces.
	`CFCF_ASSERT_SAME(a_broken_no_slip, v_o_q && broken_q, !slipping_q)
	`CFCF_ASSERT_SAME(a_broken_zero, v_o_q && broken_q, force_n_q == 32'sd0 && force_t1_q == 32'sd0)
	// An accepted word lands in the first stage.
	`CFCF_ASSERT_NEXT(a_accept_loads, inp.valid && take_s1, v_s1)
	// Slip only starts from a word that did not break.
	`CFCF_ASSERT_SAME(a_side_slip, v_s5 && side_s5.slip, !side_s5.broken)

endmodule

// ===== tb/sv/coulomb_friction_contact_force_unit_checker.sv =====
`timescale 1ns / 1ps
module coulomb_friction_contact_force_unit_checker
	import cfcf_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic       cfg_data,
	cfcf_in_if         inp,
	cfcf_out_if        res,
	output int         mismatches,
	output int         pending
);

	typedef struct packed {
		logic               broken;
		logic signed [31:0] force_n;
		logic signed [31:0] force_t1;
		logic signed [31:0] force_t2;
		logic signed [31:0] new_plastic_t1;
		logic signed [31:0] new_plastic_t2;
		logic               slipping;
	} contact_force_t;

	contact_force_t expected_forces[$];
	logic keep_tension;
	logic lock_shear;

	// Fixed-point product: magnitude truncated toward zero.
	function automatic longint fx_mul(longint a, longint unsigned b);
		longint unsigned m;
		longint unsigned p;
		m = (a < 0) ? longint'(-a) : longint'(a);
		p = (m * b) >> FRAC_BITS;
		return (a < 0) ? -longint'(p) : longint'(p);
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned int_root(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic contact_force_t contact_law(
		longint dn, longint d1, longint d2, longint pn, longint p1, longint p2,
		longint unsigned kn, longint unsigned ks, longint unsigned tf);
		contact_force_t o;
		longint fn, f1, f2, r1, r2, np1, np2;
		longint unsigned cap, a1, a2, s2, mag, ratio, one;
		r1 = d1 - p1;
		r2 = d2 - p2;
		fn = clamp32(fx_mul(dn - pn, kn));
		f1 = clamp32(fx_mul(r1, ks));
		f2 = clamp32(fx_mul(r2, ks));
		np1 = p1;
		np2 = p2;
		o = '0;
		if (fn > 0 && !keep_tension) begin
			o.broken = 1'b1;
			o.new_plastic_t1 = p1[31:0];
			o.new_plastic_t2 = p2[31:0];
			return o;
		end
		if (!lock_shear) begin
			cap = 0;
			if (fn < 0) begin
				cap = longint'(fx_mul(-fn, tf));
				if (cap > 64'hFFFF_FFFF) cap = 64'hFFFF_FFFF;
			end
			a1 = (f1 < 0) ? -f1 : f1;
			a2 = (f2 < 0) ? -f2 : f2;
			s2 = a1 * a1 + a2 * a2;
			if (s2 > cap * cap) begin
				one = 64'd1 << FRAC_BITS;
				mag = int_root(s2);
				if (mag == 0) mag = 1;
				ratio = (cap << FRAC_BITS) / mag;
				if (ratio > one) ratio = one;
				f1 = fx_mul(f1, ratio);
				f2 = fx_mul(f2, ratio);
				np1 = clamp32(p1 + fx_mul(r1, one - ratio));
				np2 = clamp32(p2 + fx_mul(r2, one - ratio));
				o.slipping = 1'b1;
			end
		end
		o.force_n = fn[31:0];
		o.force_t1 = f1[31:0];
		o.force_t2 = f2[31:0];
		o.new_plastic_t1 = np1[31:0];
		o.new_plastic_t2 = np2[31:0];
		return o;
	endfunction

	assign pending = expected_forces.size();

	always @(posedge clk or negedge arst_n) begin
		contact_force_t want;
		contact_force_t got;
		if (!arst_n) begin
			keep_tension <= 1'b0;
			lock_shear <= 1'b0;
			mismatches <= 0;
			expected_forces.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_NO_BREAK) keep_tension <= cfg_data;
				else lock_shear <= cfg_data;
			end
			if (inp.valid && inp.ready)
				expected_forces.push_back(contact_law(inp.disp_n, inp.disp_t1, inp.disp_t2,
					inp.plastic_n, inp.plastic_t1, inp.plastic_t2,
					inp.stiff_n, inp.stiff_t, inp.tan_friction));
			if (res.valid && res.ready) begin
				got = {res.broken, res.force_n, res.force_t1, res.force_t2,
					res.new_plastic_t1, res.new_plastic_t2, res.slipping};
				if (expected_forces.size() == 0) begin
					if (mismatches < 10) $display("unexpected result word %h", got);
					mismatches <= mismatches + 1;
				end else begin
					want = expected_forces.pop_front();
					if (got !== want) begin
						if (mismatches < 10) begin
							$display("mismatch: expected b=%0b fn=%h f1=%h f2=%h p1=%h p2=%h s=%0b",
								want.broken, want.force_n, want.force_t1, want.force_t2,
								want.new_plastic_t1, want.new_plastic_t2, want.slipping);
							$display("          got      b=%0b fn=%h f1=%h f2=%h p1=%h p2=%h s=%0b",
								got.broken, got.force_n, got.force_t1, got.force_t2,
								got.new_plastic_t1, got.new_plastic_t2, got.slipping);
						end
						mismatches <= mismatches + 1;
					end
				end
			end
		end
	end

endmodule

// ===== tb/sv/coulomb_friction_contact_force_unit_tb.sv =====
`timescale 1ns / 1ps
module coulomb_friction_contact_force_unit_tb;
	import cfcf_pkg::*;

	// The drain wait at Q16.16 uses a margin over the pipeline depth.
	localparam int DRAIN_CYCLES = 120;
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic cfg_data;
	int   mismatches;
	int   pending;
	int   cycle_count;
	int   words_sent;
	int   in_idle;
	int   out_idle;
	logic calm;

	cfcf_in_if  inp();
	cfcf_out_if res();

	coulomb_friction_contact_force_unit u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .inp(inp), .res(res)
	);

	coulomb_friction_contact_force_unit_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .inp(inp), .res(res), .mismatches(mismatches),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The watchdog ends a hung run.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// The result side stalls in random bursts, except in the calm tail of the run.
	initial begin
		res.ready = 1'b0;
		out_idle = 0;
		forever begin
			@(negedge clk);
			if (out_idle > 0) begin
				out_idle--;
				res.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_idle = $urandom_range(1, 13) - 1;
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	// A random 32-bit value biased toward extremes and small magnitudes, so that
	// both break and slip paths are reached often.
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'($signed($urandom_range(0, 8'hFF)) - 128) <<< 12;
			3, 4: return 32'($signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [30:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return 31'h7FFF_FFFF;
			1: return 31'd0;
			2: return 31'($urandom_range(0, 32'h4_0000));
			default: return 31'($urandom);
		endcase
	endfunction

	task automatic set_reg(input logic idx, input logic val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Holds one word on the input channel until it is taken.
	task automatic send_contact(input logic [31:0] dn, d1, d2, pn, p1, p2,
		input logic [30:0] kn, ks, tf);
		if (!calm && in_idle == 0 && $urandom_range(0, 5) == 0)
			in_idle = $urandom_range(1, 13);
		while (in_idle > 0) begin
			inp.valid <= 1'b0;
			@(negedge clk);
			in_idle--;
		end
		inp.valid <= 1'b1;
		inp.disp_n <= dn;
		inp.disp_t1 <= d1;
		inp.disp_t2 <= d2;
		inp.plastic_n <= pn;
		inp.plastic_t1 <= p1;
		inp.plastic_t2 <= p2;
		inp.stiff_n <= kn;
		inp.stiff_t <= ks;
		inp.tan_friction <= tf;
		do @(posedge clk); while (!inp.ready);
		@(negedge clk);
		words_sent++;
	endtask

	task automatic send_random();
		send_contact(pick_word(), pick_word(), pick_word(), pick_word(), pick_word(),
			pick_word(), pick_gain(), pick_gain(), pick_gain());
	endtask

	// Waits until every result is back, then lets the pipeline settle before
	// any register write.
	task automatic drain();
		inp.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_NO_BREAK;
		cfg_data = 1'b0;
		calm = 1'b0;
		in_idle = 0;
		words_sent = 0;
		inp.valid = 1'b0;
		inp.disp_n = '0;
		inp.disp_t1 = '0;
		inp.disp_t2 = '0;
		inp.plastic_n = '0;
		inp.plastic_t1 = '0;
		inp.plastic_t2 = '0;
		inp.stiff_n = '0;
		inp.stiff_t = '0;
		inp.tan_friction = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed words at reset settings: compression with and without slip,
		// tension breaking the contact, zero normal force forcing any shear to slip,
		// and the saturating extremes of every field.
		send_contact(32'hFFFF_0000, 32'h0000_1000, 32'hFFFF_F000, 0, 0, 0,
			31'h1_0000, 31'h1_0000, 31'h1_0000);
		send_contact(32'hFFFF_0000, 32'h0004_0000, 32'h0003_0000, 0, 32'h100, 32'hFFFF_FF00,
			31'h1_0000, 31'h1_0000, 31'h8000);
		send_contact(32'h0001_0000, 32'h0001_0000, 0, 0, 32'h1234, 32'hFFFF_1234,
			31'h1_0000, 31'h1_0000, 31'h1_0000);
		send_contact(0, 32'h0002_0000, 32'h0001_0000, 0, 0, 0, 31'h1_0000, 31'h1_0000, 31'd0);
		send_contact(0, 0, 0, 0, 0, 0, 31'd0, 31'd0, 31'd0);
		send_contact(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
		send_contact(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
		send_contact(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd0);
		send_contact(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 31'h1, 31'h1, 31'h1);

		// Each setting of the two registers other than the reset one, with random words, extremes included.
		for (int phase = 1; phase < 4; phase++) begin
			drain();
			set_reg(REG_NO_BREAK, phase[0]);
			set_reg(REG_NO_SLIP, phase[1]);
			send_contact(32'h0001_0000, 32'h0003_0000, 32'hFFFD_0000, 0, 0, 0,
				31'h1_0000, 31'h1_0000, 31'h1_0000);
			send_contact(0, 32'h0001_0000, 0, 0, 0, 0, 31'h1_0000, 31'h1_0000, 31'h1_0000);
			repeat (100) send_random();
		end

		// Back to reset settings for a further run of random words.
		drain();
		set_reg(REG_NO_BREAK, 1'b0);
		set_reg(REG_NO_SLIP, 1'b0);
		repeat (150) send_random();
		calm = 1'b1;
		repeat (60) send_random();
		drain();

		if (mismatches == 0 && pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
